// ===== src/lph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, operation and result codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lph_pkg;

   // Default number of slots in the table.
   localparam int DEF_TABLE_SIZE = 16;

   // Field widths of the request and response items.
   localparam int OP_W         = 2;
   localparam int KEY_W        = 32;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 3;
   localparam int SLOT_W       = 4;
   localparam int SLOT_STATE_W = 2;

   // One table entry: slot state, key and data word.
   localparam int ENTRY_W = SLOT_STATE_W + KEY_W + VALUE_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // Result codes.
   localparam logic [STATUS_W-1:0] RS_NEW     = 3'd0;
   localparam logic [STATUS_W-1:0] RS_UPDATED = 3'd1;
   localparam logic [STATUS_W-1:0] RS_DELETED = 3'd2;
   localparam logic [STATUS_W-1:0] RS_MISSING = 3'd3;
   localparam logic [STATUS_W-1:0] RS_FULL    = 3'd4;
   localparam logic [STATUS_W-1:0] RS_FOUND   = 3'd5;

   // Slot states.
   localparam logic [SLOT_STATE_W-1:0] ST_EMPTY = 2'd0;
   localparam logic [SLOT_STATE_W-1:0] ST_USED  = 2'd1;
   localparam logic [SLOT_STATE_W-1:0] ST_TOMB  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic hash_step;
      logic probe_start;
      logic probe_step;
      logic finish;
      logic clear_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic hash_done;
      logic probe_done;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== src/lph_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface lph_req_if;
   logic                              valid;
   logic                              ready;
   logic [lph_pkg::OP_W-1:0]          op;
   logic [lph_pkg::KEY_W-1:0]         key;
   logic signed [lph_pkg::VALUE_W-1:0] value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lph_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lph_pkg::STATUS_W-1:0]       status;
   logic signed [lph_pkg::VALUE_W-1:0] found_value;
   logic [lph_pkg::SLOT_W-1:0]         slot;

   modport source (output valid, output status, output found_value, output slot,
                   input ready);
   modport sink   (input valid, input status, input found_value, input slot,
                   output ready);
endinterface

// ===== src/lph_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/lph_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences the clearing pass, the hash, the probe walk and the write-back.
// ----------------------------------------------------------------------------
module lph_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lph_pkg::stat_type stat,
   output lph_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_START  = 3'd3;
   localparam logic [2:0] S_PROBE  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_done) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.probe_start = 1'b1;
            state_in        = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe_step = 1'b1;
            if (stat.probe_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/lph_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Holds the item, computes the home slot, walks the probe chain through the
// entry RAM and writes back the result.
// ----------------------------------------------------------------------------
module lph_datapath #(
   parameter int TABLE_SIZE = lph_pkg::DEF_TABLE_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lph_pkg::cmd_type                    cmd,
   output lph_pkg::stat_type                   stat,
   input  logic [lph_pkg::OP_W-1:0]            req_op,
   input  logic [lph_pkg::KEY_W-1:0]           req_key,
   input  logic signed [lph_pkg::VALUE_W-1:0]  req_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [lph_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [lph_pkg::VALUE_W-1:0]  rsp_found_value,
   output logic [lph_pkg::SLOT_W-1:0]          rsp_slot
);

   localparam int              IW       = $clog2(TABLE_SIZE);
   localparam logic [IW-1:0]   LAST_IDX = IW'(TABLE_SIZE - 1);
   localparam logic [IW:0]     MODULUS  = (IW + 1)'(TABLE_SIZE);
   localparam bit              IS_POW2  = (TABLE_SIZE == (1 << IW));

   // Low word of the reciprocal floor(2^(32+IW) / TABLE_SIZE) + 1; the full
   // multiplier is 2^32 plus this word, which gives the exact quotient of
   // any 32-bit key when the table size is not a power of two.
   localparam logic [lph_pkg::KEY_W-1:0] RECIP_LO = lph_pkg::KEY_W'(
      (64'd1 << lph_pkg::KEY_W) * 64'((1 << IW) - TABLE_SIZE) / 64'(TABLE_SIZE) + 64'd1);

   // Item registers.
   logic [lph_pkg::OP_W-1:0]    op_ff;
   logic [lph_pkg::KEY_W-1:0]   key_ff;
   logic [lph_pkg::VALUE_W-1:0] value_ff;

   // Home slot computation.
   logic                          hphase_ff;
   logic [2*lph_pkg::KEY_W-1:0]   mul_lo;
   logic [2*lph_pkg::KEY_W:0]     prod_in;
   logic [2*lph_pkg::KEY_W:0]     prod_ff;
   logic [IW-1:0]                 quo_lo;
   logic [2*IW:0]                 qn;
   logic [IW-1:0]                 rem_ff;
   logic [IW-1:0]                 rem_in;
   logic [IW-1:0]                 home_idx;

   // Probe walk.
   logic [IW-1:0]               issue_idx_ff;
   logic [IW-1:0]               data_idx_ff;
   logic [IW-1:0]               pcnt_ff;
   logic                        hit_ff;
   logic [IW-1:0]               hit_idx_ff;
   logic [lph_pkg::VALUE_W-1:0] hit_value_ff;
   logic                        free_ff;
   logic [IW-1:0]               free_idx_ff;

   // Entry RAM ports.
   logic                            wr_en;
   logic [IW-1:0]                   wr_addr;
   logic [lph_pkg::ENTRY_W-1:0]     wr_data;
   logic [IW-1:0]                   rd_addr;
   logic [lph_pkg::ENTRY_W-1:0]     rd_data;
   logic [lph_pkg::SLOT_STATE_W-1:0] rd_state;
   logic [lph_pkg::KEY_W-1:0]       rd_key;
   logic [lph_pkg::VALUE_W-1:0]     rd_value;
   logic                            key_match;

   // Result and response.
   logic                            res_write;
   logic [IW-1:0]                   res_idx;
   logic [lph_pkg::ENTRY_W-1:0]     res_entry;
   logic [lph_pkg::STATUS_W-1:0]    res_status;
   logic [lph_pkg::VALUE_W-1:0]     res_found;
   logic [IW-1:0]                   res_slot;
   logic [IW-1:0]                   clear_idx_ff;
   logic                            rsp_valid_ff;
   logic [lph_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [lph_pkg::VALUE_W-1:0]     rsp_found_ff;
   logic [lph_pkg::SLOT_W-1:0]      rsp_slot_ff;

   // Next slot on the chain, with wraparound.
   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   // First hash step: key times the reciprocal, the quotient sits above
   // bit 32+IW. Second step: the remainder from the low bits of key minus
   // quotient times table size, which is exact since it is below 2^IW.
   assign mul_lo  = {{lph_pkg::KEY_W{1'b0}}, key_ff} * {{lph_pkg::KEY_W{1'b0}}, RECIP_LO};
   assign prod_in = {1'b0, key_ff, {lph_pkg::KEY_W{1'b0}}} + {1'b0, mul_lo};
   assign quo_lo  = prod_ff[lph_pkg::KEY_W + IW +: IW];
   assign qn      = {{(IW + 1){1'b0}}, quo_lo} * {{IW{1'b0}}, MODULUS};
   assign rem_in  = key_ff[IW-1:0] - qn[IW-1:0];

   // A power-of-two table takes the low key bits directly.
   assign home_idx       = IS_POW2 ? key_ff[IW-1:0] : rem_ff;
   assign stat.hash_done = IS_POW2 || hphase_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         key_ff    <= req_key;
         value_ff  <= req_value;
         hphase_ff <= 1'b0;
      end else if (cmd.hash_step) begin
         if (!hphase_ff) begin
            prod_ff   <= prod_in;
            hphase_ff <= 1'b1;
         end else begin
            rem_ff <= rem_in;
         end
      end
   end

   // Entry RAM: the read address runs one slot ahead of the evaluated data.
   assign rd_addr   = cmd.probe_start ? home_idx : issue_idx_ff;
   assign rd_state  = rd_data[lph_pkg::ENTRY_W-1 -: lph_pkg::SLOT_STATE_W];
   assign rd_key    = rd_data[lph_pkg::VALUE_W +: lph_pkg::KEY_W];
   assign rd_value  = rd_data[lph_pkg::VALUE_W-1:0];
   assign key_match = (rd_state == lph_pkg::ST_USED) && (rd_key == key_ff);

   // The walk ends at an empty slot, at a match, or after the last slot.
   assign stat.probe_done = (rd_state == lph_pkg::ST_EMPTY) || key_match ||
                            (pcnt_ff == LAST_IDX);

   lph_ram #(
      .WIDTH (lph_pkg::ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Probe bookkeeping: first free slot and the matching slot.
   always_ff @(posedge clock) begin
      if (cmd.probe_start) begin
         issue_idx_ff <= next_idx(home_idx);
         data_idx_ff  <= home_idx;
         pcnt_ff      <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else if (cmd.probe_step) begin
         issue_idx_ff <= next_idx(issue_idx_ff);
         data_idx_ff  <= issue_idx_ff;
         pcnt_ff      <= pcnt_ff + 1'b1;
         if (!free_ff && (rd_state != lph_pkg::ST_USED)) begin
            free_ff     <= 1'b1;
            free_idx_ff <= data_idx_ff;
         end
         if (key_match) begin
            hit_ff       <= 1'b1;
            hit_idx_ff   <= data_idx_ff;
            hit_value_ff <= rd_value;
         end
      end
   end

   // Outcome of the item once the walk is over.
   always_comb begin
      res_write  = 1'b0;
      res_idx    = hit_idx_ff;
      res_entry  = {lph_pkg::ST_USED, key_ff, value_ff};
      res_status = lph_pkg::RS_MISSING;
      res_found  = '0;
      res_slot   = '0;
      case (op_ff)
         lph_pkg::OP_INSERT: begin
            if (hit_ff) begin
               res_write  = 1'b1;
               res_status = lph_pkg::RS_UPDATED;
               res_slot   = hit_idx_ff;
            end else if (free_ff) begin
               res_write  = 1'b1;
               res_idx    = free_idx_ff;
               res_status = lph_pkg::RS_NEW;
               res_slot   = free_idx_ff;
            end else begin
               res_status = lph_pkg::RS_FULL;
            end
         end
         lph_pkg::OP_DELETE: begin
            if (hit_ff) begin
               res_write  = 1'b1;
               res_entry  = {lph_pkg::ST_TOMB, key_ff, hit_value_ff};
               res_status = lph_pkg::RS_DELETED;
               res_slot   = hit_idx_ff;
            end
         end
         lph_pkg::OP_LOOKUP: begin
            if (hit_ff) begin
               res_status = lph_pkg::RS_FOUND;
               res_found  = hit_value_ff;
               res_slot   = hit_idx_ff;
            end
         end
         default: begin
            res_status = lph_pkg::RS_MISSING;
         end
      endcase
   end

   // Write port: clearing pass after reset, otherwise the write-back.
   always_comb begin
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clear_idx_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.finish && res_write;
         wr_addr = res_idx;
         wr_data = res_entry;
      end
   end

   assign stat.clear_last = (clear_idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_idx_ff <= next_idx(clear_idx_ff);
      end
   end

   // Response register; it holds a result until the sink takes the item.
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= res_status;
         rsp_found_ff  <= res_found;
         rsp_slot_ff   <= lph_pkg::SLOT_W'(res_slot);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_slot        = rsp_slot_ff;

endmodule

// ===== src/linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table core
// Open-addressing key/data table with linear probing, insert, delete and
// lookup, one response item for each request item.
// ----------------------------------------------------------------------------
// After reset the core clears every slot of the table and accepts no request
// item until that pass is done. An item is then accepted, hashed (directly
// from the low key bits when TABLE_SIZE is a power of two; otherwise a
// reciprocal multiplication for the quotient, then the remainder), the walk
// is started and the probe steps run (one slot per cycle through the entry
// RAM read port, ending at an empty slot, a matching key or the last slot),
// and a write-back step, which waits while a held result is not yet taken,
// loads the response register. The next item is accepted while a result
// still waits in the response register.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
   parameter int TABLE_SIZE = lph_pkg::DEF_TABLE_SIZE
) (
   input logic       clock,
   input logic       reset,
   lph_req_if.sink   req_chan,
   lph_rsp_if.source rsp_chan
);

   lph_pkg::cmd_type  cmd;
   lph_pkg::stat_type stat;

   // Sequencer.
   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table storage, hash and probe logic.
   lph_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_chan.op),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_found_value (rsp_chan.found_value),
      .rsp_slot        (rsp_chan.slot)
   );

endmodule

// ===== dv/linear_probe_hash_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table core testbench
// Drives insert, delete and lookup items into the core and compares every
// response item with the one that the directed list gives, or else with
// one from a behavioral copy of the table kept here. A short list of directed
// items comes first, then random traffic over a small key pool so chains,
// tombstones and a full table come up often. Both channels idle at random,
// and the response side holds off twice for a long stretch.
module linear_probe_hash_table_core_tb;

   localparam int TABLE_SIZE    = lph_pkg::DEF_TABLE_SIZE;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int KEY_POOL_SIZE = 24;
   localparam int DRAIN_CYCLES  = 50;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int LONG_HOLD     = 500;

   // Op code that the core does not define; it must report a miss.
   localparam logic [lph_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [lph_pkg::OP_W-1:0]           op;
      logic [lph_pkg::KEY_W-1:0]          key;
      logic signed [lph_pkg::VALUE_W-1:0] value;
   } hash_req_type;

   typedef struct packed {
      logic [lph_pkg::STATUS_W-1:0]       status;
      logic signed [lph_pkg::VALUE_W-1:0] found_value;
      logic [lph_pkg::SLOT_W-1:0]         slot;
   } hash_rsp_type;

   typedef struct {
      hash_req_type req;
      bit           known;
      hash_rsp_type rsp;
   } plan_row_type;

   logic clock;
   logic reset;

   lph_req_if req_chan ();
   lph_rsp_if rsp_chan ();

   linear_probe_hash_table_core #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Behavioral copy of the table.
   logic [lph_pkg::SLOT_STATE_W-1:0] model_state [TABLE_SIZE];
   logic [lph_pkg::KEY_W-1:0]        model_key   [TABLE_SIZE];
   logic [lph_pkg::VALUE_W-1:0]      model_data  [TABLE_SIZE];

   hash_rsp_type  pending_rsp [$];
   plan_row_type  plan_rows [$];
   int            error_count  = 0;
   int            req_accepted = 0;
   int            cycle_count  = 0;
   bit            steady_mode  = 1'b0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count == CYCLE_LIMIT);
      $display("linear_probe_hash_table_core test failed");
      $finish;
   end

   // Applies one item to the table copy and returns the response it causes.
   function automatic hash_rsp_type hash_table_apply(hash_req_type rq);
      hash_rsp_type res;
      int           idx;
      int           hit;
      int           free_slot;
      bit           stop;
      res.status      = lph_pkg::RS_MISSING;
      res.found_value = '0;
      res.slot        = '0;
      hit             = -1;
      free_slot       = -1;
      // Walk the chain for a matching key, stopping at an empty slot.
      if (rq.op != OP_UNUSED) begin
         idx  = int'(rq.key % TABLE_SIZE);
         stop = 1'b0;
         for (int n = 0; n < TABLE_SIZE; n++) begin
            if (!stop) begin
               if (model_state[idx] == lph_pkg::ST_EMPTY) begin
                  stop = 1'b1;
               end else if (model_state[idx] == lph_pkg::ST_USED &&
                            model_key[idx] == rq.key) begin
                  hit  = idx;
                  stop = 1'b1;
               end else begin
                  idx = (idx + 1) % TABLE_SIZE;
               end
            end
         end
      end
      case (rq.op)
         lph_pkg::OP_INSERT: begin
            if (hit >= 0) begin
               model_data[hit] = rq.value;
               res.status      = lph_pkg::RS_UPDATED;
               res.slot        = lph_pkg::SLOT_W'(hit);
            end else begin
               // New key: first tombstone or empty slot on the chain.
               idx = int'(rq.key % TABLE_SIZE);
               for (int n = 0; n < TABLE_SIZE; n++) begin
                  if (free_slot < 0) begin
                     if (model_state[idx] != lph_pkg::ST_USED) begin
                        free_slot = idx;
                     end else begin
                        idx = (idx + 1) % TABLE_SIZE;
                     end
                  end
               end
               if (free_slot >= 0) begin
                  model_state[free_slot] = lph_pkg::ST_USED;
                  model_key[free_slot]   = rq.key;
                  model_data[free_slot]  = rq.value;
                  res.status             = lph_pkg::RS_NEW;
                  res.slot               = lph_pkg::SLOT_W'(free_slot);
               end else begin
                  res.status = lph_pkg::RS_FULL;
               end
            end
         end
         lph_pkg::OP_DELETE: begin
            if (hit >= 0) begin
               model_state[hit] = lph_pkg::ST_TOMB;
               res.status       = lph_pkg::RS_DELETED;
               res.slot         = lph_pkg::SLOT_W'(hit);
            end
         end
         lph_pkg::OP_LOOKUP: begin
            if (hit >= 0) begin
               res.status      = lph_pkg::RS_FOUND;
               res.found_value = model_data[hit];
               res.slot        = lph_pkg::SLOT_W'(hit);
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Gap lengths: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_mode || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("@%0d ns: %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic plan_item(logic [lph_pkg::OP_W-1:0] op, logic [lph_pkg::KEY_W-1:0] key,
                            logic [lph_pkg::VALUE_W-1:0] value);
      plan_row_type row;
      row.req.op    = op;
      row.req.key   = key;
      row.req.value = value;
      row.known     = 1'b0;
      row.rsp       = '0;
      plan_rows.push_back(row);
   endtask

   task automatic plan_known(logic [lph_pkg::OP_W-1:0] op, logic [lph_pkg::KEY_W-1:0] key,
                             logic [lph_pkg::VALUE_W-1:0] value,
                             logic [lph_pkg::STATUS_W-1:0] status,
                             logic [lph_pkg::VALUE_W-1:0] found_value,
                             logic [lph_pkg::SLOT_W-1:0] slot);
      plan_row_type row;
      row.req.op          = op;
      row.req.key         = key;
      row.req.value       = value;
      row.known           = 1'b1;
      row.rsp.status      = status;
      row.rsp.found_value = found_value;
      row.rsp.slot        = slot;
      plan_rows.push_back(row);
   endtask

   // Offers one item and records its expected response once it is accepted.
   task automatic offer_item(hash_req_type rq, bit known, hash_rsp_type known_rsp);
      int           gap;
      hash_rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= rq.op;
      req_chan.key   <= rq.key;
      req_chan.value <= rq.value;
      do @(posedge clock); while (!req_chan.ready);
      predicted = hash_table_apply(rq);
      pending_rsp.push_back(known ? known_rsp : predicted);
      req_accepted++;
   endtask

   // Request side: reset, directed list, then random traffic.
   initial begin : req_side
      logic [lph_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
      hash_req_type              rq;
      int                        insert_pct;
      int                        r;
      foreach (model_state[i]) begin
         model_state[i] = lph_pkg::ST_EMPTY;
         model_key[i]   = '0;
         model_data[i]  = '0;
      end
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op    <= lph_pkg::OP_INSERT;
      req_chan.key   <= '0;
      req_chan.value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty table, undefined op code, and the extremes of key and data.
      plan_known(lph_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0, lph_pkg::RS_MISSING,
                 32'h0, 4'd0);
      plan_known(OP_UNUSED, 32'h0000_0005, 32'h9, lph_pkg::RS_MISSING, 32'h0, 4'd0);
      plan_known(lph_pkg::OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF, lph_pkg::RS_NEW,
                 32'h0, 4'd0);
      plan_known(lph_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, lph_pkg::RS_NEW,
                 32'h0, 4'd15);
      plan_known(lph_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0, lph_pkg::RS_FOUND,
                 32'h7FFF_FFFF, 4'd0);
      plan_known(lph_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, lph_pkg::RS_FOUND,
                 32'h8000_0000, 4'd15);
      // Collision, update, tombstone reuse and no duplicate past a tombstone.
      plan_item(lph_pkg::OP_INSERT, 32'd16, 32'd1);
      plan_item(lph_pkg::OP_INSERT, 32'd0, 32'hFFFF_FFFF);
      plan_item(lph_pkg::OP_DELETE, 32'd0, 32'h0);
      plan_item(lph_pkg::OP_INSERT, 32'd32, 32'd5);
      plan_item(lph_pkg::OP_INSERT, 32'd16, 32'd2);
      // Home in the last slot, so the probe wraps to the start.
      plan_item(lph_pkg::OP_INSERT, 32'd31, 32'h5A5A_5A5A);
      // Fill the remaining slots.
      for (int k = 3; k < TABLE_SIZE - 1; k++) begin
         plan_item(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(k),
                   lph_pkg::VALUE_W'(k) * 32'h0101_0101);
      end
      // Full table: a new key is refused and a missing key probes every slot.
      plan_known(lph_pkg::OP_INSERT, 32'd64, 32'd7, lph_pkg::RS_FULL, 32'h0, 4'd0);
      plan_known(lph_pkg::OP_LOOKUP, 32'd48, 32'h0, lph_pkg::RS_MISSING, 32'h0, 4'd0);

      foreach (plan_rows[i]) begin
         offer_item(plan_rows[i].req, plan_rows[i].known, plan_rows[i].rsp);
      end

      // Random traffic over a small key pool with noise keys mixed in.
      foreach (key_pool[i]) begin
         key_pool[i] = $urandom();
      end
      insert_pct = 45;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            r          = $urandom_range(0, 2);
            insert_pct = (r == 0) ? 25 : (r == 1) ? 45 : 70;
         end
         if (n % 150 == 0) begin
            steady_mode = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 49) == 0) begin
            key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = $urandom();
         end

         r = $urandom_range(0, 99);
         if (r < 2) begin
            rq.op = OP_UNUSED;
         end else if (r < 2 + insert_pct) begin
            rq.op = lph_pkg::OP_INSERT;
         end else if (r < 2 + insert_pct + (98 - insert_pct) / 2) begin
            rq.op = lph_pkg::OP_DELETE;
         end else begin
            rq.op = lph_pkg::OP_LOOKUP;
         end

         r = $urandom_range(0, 99);
         if (r < 78) begin
            rq.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         end else if (r < 94) begin
            rq.key = $urandom();
         end else if (r < 97) begin
            rq.key = 32'h0000_0000;
         end else begin
            rq.key = 32'hFFFF_FFFF;
         end

         r = $urandom_range(0, 19);
         if (r == 0) begin
            rq.value = 32'h8000_0000;
         end else if (r == 1) begin
            rq.value = 32'h7FFF_FFFF;
         end else begin
            rq.value = $urandom();
         end

         offer_item(rq, 1'b0, '0);
      end

      // Drain the outstanding responses, then let the core settle.
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("linear_probe_hash_table_core test passed");
      end else begin
         $display("linear_probe_hash_table_core test failed");
      end
      $finish;
   end

   // Response side: check each accepted item and drive random back-pressure.
   initial begin : rsp_side
      hash_rsp_type want;
      int           hold_cycles;
      bit           first_hold_done;
      bit           second_hold_done;
      hold_cycles      = 0;
      first_hold_done  = 1'b0;
      second_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response item with no request outstanding",
                               32'(rsp_chan.status), 32'h0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_chan.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
               end
               if (rsp_chan.found_value !== want.found_value) begin
                  report_mismatch("found_value", rsp_chan.found_value, want.found_value);
               end
               if (rsp_chan.slot !== want.slot) begin
                  report_mismatch("slot", 32'(rsp_chan.slot), 32'(want.slot));
               end
            end
         end

         // Long hold-offs so the core fills up and stalls its input.
         if (!first_hold_done && req_accepted >= 400) begin
            first_hold_done = 1'b1;
            hold_cycles     = LONG_HOLD;
         end else if (!second_hold_done && req_accepted >= 1000) begin
            second_hold_done = 1'b1;
            hold_cycles      = LONG_HOLD;
         end else if (hold_cycles == 0 && !reset && $urandom_range(0, 3) == 0) begin
            hold_cycles = pick_gap();
         end

         if (hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

endmodule
